// File: rtl/scbd_pkg.sv
// Shared types and constants for the servo command byte decoder.
// No dependencies; imported by every module of the block except scbd_ram.
package scbd_pkg;

	// Defaults for the top-level parameters
	localparam int STACK_DEPTH_DEF = 16;
	localparam int SERVO_COUNT_DEF = 8;

	// Port widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [15:0] ANGLE_LIMIT_RST   = 16'd8000;
	localparam logic [7:0]  PREAMBLE_CODE_RST = 8'd255;
	localparam logic [7:0]  ESCAPE_CODE_RST   = 8'd254;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ANGLE_LIMIT   = 2'd0,
		REG_PREAMBLE_CODE = 2'd1,
		REG_ESCAPE_CODE   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_CMD   = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		CMD_SET_SERVO   = 4'd0,
		CMD_LED         = 4'd1,
		CMD_POWER       = 4'd2,
		CMD_CLEAR       = 4'd3,
		CMD_QUERY_SERVO = 4'd4,
		CMD_GET_LED     = 4'd5,
		CMD_GET_POWER   = 4'd6
	} cmd_t;

	typedef enum logic [1:0] {
		PK_NONE  = 2'd0,
		PK_SERVO = 2'd1,
		PK_LED   = 2'd2,
		PK_POWER = 2'd3
	} push_kind_t;

	// Per-beat control handed from the parser to the later stage
	typedef struct packed {
		logic       is_read;
		logic       seen;
		logic       ang_wr;
		push_kind_t kind;
		logic       push_lo;
		logic       push_hi;
	} ctl_t;

endpackage

// File: rtl/scbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/scbd_parser.sv
// Byte parser: running sum, parse phase, LED/power state and reply count.
// Depends on scbd_pkg.
module scbd_parser #(
	parameter int STACK_DEPTH = scbd_pkg::STACK_DEPTH_DEF,
	parameter int SERVO_COUNT = scbd_pkg::SERVO_COUNT_DEF,
	localparam int SW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                op,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         angle_limit,
	input  logic [7:0]          preamble_code,
	input  logic [7:0]          escape_code,
	output scbd_pkg::ctl_t      ctl,
	output logic [SW-1:0]       ang_idx,
	output logic [15:0]         ang_val,
	output logic [SW-1:0]       servo_rd_idx,
	output logic [AW-1:0]       pop_slot,
	output logic [AW-1:0]       push_slot,
	output logic [2:0]          led_next,
	output logic [2:0]          mask_next,
	output logic                pwr_next
);
	import scbd_pkg::*;

	phase_t        phase_q, phase_d;
	logic [7:0]    sum_q, sum_d, sum_w;
	logic [7:0]    high_q, high_d;
	logic [SW-1:0] pend_q, pend_d;
	logic [2:0]    led_q, mask_q;
	logic          pwr_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          is_pre, is_esc, done, cmd_go;
	cmd_t          cmd;
	logic [3:0]    ext;
	logic [2:0]    sel;
	logic [SW-1:0] ext_idx;
	logic [15:0]   raw_ang;

	assign sum_w  = sum_q + data_byte;
	assign is_pre = (data_byte == preamble_code);
	assign is_esc = (data_byte == escape_code);
	assign done   = !op && !is_pre && !is_esc;
	assign cmd_go = done && ((phase_q == PH_CMD) || (phase_q == PH_SPARE));
	assign cmd    = cmd_t'(sum_w[7:4]);
	assign ext    = sum_w[3:0];
	assign sel    = ext[2:0];
	assign raw_ang = {high_q, sum_w};

	// ext modulo servo count as a small table
	always_comb begin
		ext_idx = '0;
		for (int i = 0; i < 16; i++) begin
			if (ext == 4'(i)) begin
				ext_idx = SW'(i % SERVO_COUNT);
			end
		end
	end

	// Next parse phase
	always_comb begin
		phase_d = phase_q;
		if (!op) begin
			if (is_pre) begin
				phase_d = PH_CMD;
			end else if (!is_esc) begin
				unique case (phase_q)
					PH_HIGH: phase_d = PH_LOW;
					PH_LOW:  phase_d = PH_CMD;
					PH_CMD, PH_SPARE: begin
						phase_d = (cmd == CMD_SET_SERVO) ? PH_HIGH : PH_CMD;
					end
				endcase
			end
		end
	end

	// Decode outputs and datapath next values
	always_comb begin
		ctl       = '0;
		ctl.kind  = PK_NONE;
		sum_d     = sum_q;
		high_d    = high_q;
		pend_d    = pend_q;
		led_next  = led_q;
		mask_next = mask_q;
		pwr_next  = pwr_q;
		cnt_d     = cnt_q;
		ang_val   = (raw_ang > angle_limit) ? angle_limit : raw_ang;

		if (op) begin
			ctl.is_read = 1'b1;
			if (cnt_q != '0) begin
				cnt_d = cnt_q - CW'(1);
			end
		end else if (is_pre) begin
			sum_d = '0;
		end else if (is_esc) begin
			sum_d = sum_w;
		end else begin
			sum_d = '0;
			if (phase_q == PH_HIGH) begin
				high_d = sum_w;
			end else if (phase_q == PH_LOW) begin
				ctl.ang_wr = 1'b1;
			end
		end

		if (cmd_go) begin
			ctl.seen = 1'b1;
			unique case (cmd)
				CMD_SET_SERVO: pend_d = ext_idx;
				CMD_LED: begin
					mask_next = mask_q | sel;
					led_next  = ext[3] ? (led_q | sel) : (led_q & ~sel);
				end
				CMD_POWER: pwr_next = |ext;
				CMD_CLEAR: cnt_d = '0;
				CMD_QUERY_SERVO: begin
					ctl.kind    = PK_SERVO;
					ctl.push_lo = (cnt_q < CW'(STACK_DEPTH));
					ctl.push_hi = (cnt_q < CW'(STACK_DEPTH - 1));
				end
				CMD_GET_LED: begin
					ctl.kind    = PK_LED;
					ctl.push_lo = (cnt_q < CW'(STACK_DEPTH));
				end
				CMD_GET_POWER: begin
					ctl.kind    = PK_POWER;
					ctl.push_lo = (cnt_q < CW'(STACK_DEPTH));
				end
				default: ;
			endcase
			cnt_d = cnt_d + CW'(ctl.push_lo) + CW'(ctl.push_hi);
		end
	end

	assign ang_idx      = pend_q;
	assign servo_rd_idx = ext_idx;
	assign pop_slot     = cnt_d[AW-1:0];
	assign push_slot    = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			sum_q   <= '0;
			high_q  <= '0;
			pend_q  <= '0;
			led_q   <= '0;
			mask_q  <= '0;
			pwr_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			high_q  <= high_d;
			pend_q  <= pend_d;
			led_q   <= led_next;
			mask_q  <= mask_next;
			pwr_q   <= pwr_next;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/scbd_stack.sv
// Reply stack storage: even/odd RAM banks, per-slot valid bits, pop forwarding.
// Depends on scbd_pkg and scbd_ram.
module scbd_stack #(
	parameter int STACK_DEPTH = scbd_pkg::STACK_DEPTH_DEF,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_go,
	input  logic          lo_en,
	input  logic          hi_en,
	input  logic [AW-1:0] lo_slot,
	input  logic [7:0]    lo_data,
	input  logic [7:0]    hi_data,
	input  logic          pop_go,
	input  logic [AW-1:0] pop_slot,
	output logic [7:0]    pop_byte
);
	import scbd_pkg::*;

	localparam int BD = (STACK_DEPTH + 1) / 2;
	localparam int RW = (BD > 1) ? $clog2(BD) : 1;

	logic [AW-1:0]          hi_slot;
	logic [RW-1:0]          lo_row, hi_row, pop_row;
	logic                   lo_even, hi_even;
	logic                   we_e, we_o;
	logic [RW-1:0]          wa_e, wa_o;
	logic [7:0]             wd_e, wd_o, q_e, q_o;
	logic [STACK_DEPTH-1:0] vld_q;
	logic [AW-1:0]          pop_slot_q;
	logic                   fwd_hit_q;
	logic [7:0]             fwd_q;

	assign hi_slot = lo_slot + AW'(1);
	assign lo_row  = RW'(lo_slot >> 1);
	assign hi_row  = RW'(hi_slot >> 1);
	assign pop_row = RW'(pop_slot >> 1);
	assign lo_even = lo_en && !lo_slot[0];
	assign hi_even = hi_en && !hi_slot[0];

	// A two-byte push always lands one byte in each bank
	always_comb begin
		we_e = wr_go && (lo_even || hi_even);
		wa_e = lo_even ? lo_row : hi_row;
		wd_e = lo_even ? lo_data : hi_data;
		we_o = wr_go && ((lo_en && lo_slot[0]) || (hi_en && hi_slot[0]));
		wa_o = (lo_en && lo_slot[0]) ? lo_row : hi_row;
		wd_o = (lo_en && lo_slot[0]) ? lo_data : hi_data;
	end

	scbd_ram #(.WIDTH(8), .DEPTH(BD)) u_bank_e (
		.clk(clk), .we(we_e), .waddr(wa_e), .wdata(wd_e),
		.re(pop_go), .raddr(pop_row), .rdata(q_e)
	);

	scbd_ram #(.WIDTH(8), .DEPTH(BD)) u_bank_o (
		.clk(clk), .we(we_o), .waddr(wa_o), .wdata(wd_o),
		.re(pop_go), .raddr(pop_row), .rdata(q_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			fwd_hit_q  <= 1'b0;
			pop_slot_q <= '0;
		end else begin
			if (wr_go && lo_en) begin
				vld_q[lo_slot] <= 1'b1;
			end
			if (wr_go && hi_en) begin
				vld_q[hi_slot] <= 1'b1;
			end
			if (pop_go) begin
				pop_slot_q <= pop_slot;
				fwd_hit_q  <= wr_go && ((lo_en && (lo_slot == pop_slot)) ||
					(hi_en && (hi_slot == pop_slot)));
			end
		end
	end

	// Push landing in the same cycle as the pop read: take its byte instead
	always_ff @(posedge clk) begin
		if (pop_go) begin
			fwd_q <= (lo_en && (lo_slot == pop_slot)) ? lo_data : hi_data;
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			pop_byte = fwd_q;
		end else if (vld_q[pop_slot_q]) begin
			pop_byte = pop_slot_q[0] ? q_o : q_e;
		end else begin
			pop_byte = 8'h00;
		end
	end

endmodule

// File: rtl/servo_command_byte_decoder.sv
// Top level of the servo command byte decoder: config registers, servo angle
// table, pipeline and output register. Depends on scbd_pkg, scbd_ram,
// scbd_parser and scbd_stack.
//
// Takes one bus beat per clock and returns one result beat per input beat,
// after the parse stage and then the output register, at a sustained rate
// of one beat per cycle; only output backpressure slows it. A write beat is
// parsed on acceptance (running escape sum, preamble reset, command, angle
// high and low bytes). Servo angles live in a one-read/one-write RAM, written
// when the low angle byte is accepted and read for a get-servo query in the
// same cycle; its data is used in stage 1. The reply stack lives in two RAM banks
// (even and odd slots) so the two bytes of a servo query are pushed in the same
// cycle; a read beat pops on acceptance and a push landing on that slot in the
// same cycle is forwarded. Entries never written read as zero through per-entry
// valid bits, so there is no clearing pass after reset. Configuration registers
// are written through cfg_we/cfg_addr/cfg_wdata; the user must do so only while
// the block is idle (not enforced); indexes beyond the register list are ignored.
module servo_command_byte_decoder #(
	parameter int STACK_DEPTH = scbd_pkg::STACK_DEPTH_DEF,
	parameter int SERVO_COUNT = scbd_pkg::SERVO_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input beats
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scbd_pkg::IN_DATA_W-1:0]      s_tdata,  // data_byte[7:0], power_sense[8]
	input  logic                                s_tuser,  // op: 0 write, 1 read
	// Result beats
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// read_data[7:0], command_seen[8], angle_write[9], angle_index[12:10],
	// angle_value[28:13], led_state[31:29], led_user_mask[34:32], servo_power[35]
	output logic [scbd_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Configuration writes
	input  logic                                cfg_we,
	input  logic [scbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [scbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import scbd_pkg::*;

	localparam int SW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam int AW = $clog2(STACK_DEPTH);

	// Config registers
	logic [15:0] angle_limit_q;
	logic [7:0]  preamble_q, escape_q;

	// Handshake and pipeline control
	logic fire, adv, vld_s1, out_vld_q;

	// Parser outputs
	ctl_t          ctl;
	logic [SW-1:0] ang_idx, servo_rd_idx;
	logic [15:0]   ang_val;
	logic [AW-1:0] pop_slot, push_slot;
	logic [2:0]    led_next, mask_next;
	logic          pwr_next;

	// Stage 1 registers
	ctl_t          ctl_s1;
	logic [SW-1:0] ang_idx_s1, srv_idx_s1;
	logic [15:0]   ang_val_s1;
	logic [AW-1:0] push_slot_s1;
	logic [2:0]    led_s1, mask_s1;
	logic          pwr_s1, psense_s1;

	// Servo table
	logic [SERVO_COUNT-1:0] svld_q;
	logic [15:0]            servo_q, angle_rd;

	// Reply stack
	logic [7:0] lo_data, hi_data, pop_byte;

	logic [OUT_DATA_W-1:0] out_q, out_d;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign fire     = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// Config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q <= ANGLE_LIMIT_RST;
			preamble_q    <= PREAMBLE_CODE_RST;
			escape_q      <= ESCAPE_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ANGLE_LIMIT:   angle_limit_q <= cfg_wdata;
				REG_PREAMBLE_CODE: preamble_q    <= cfg_wdata[7:0];
				REG_ESCAPE_CODE:   escape_q      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	scbd_parser #(.STACK_DEPTH(STACK_DEPTH), .SERVO_COUNT(SERVO_COUNT)) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.op            (s_tuser),
		.data_byte     (s_tdata[7:0]),
		.angle_limit   (angle_limit_q),
		.preamble_code (preamble_q),
		.escape_code   (escape_q),
		.ctl           (ctl),
		.ang_idx       (ang_idx),
		.ang_val       (ang_val),
		.servo_rd_idx  (servo_rd_idx),
		.pop_slot      (pop_slot),
		.push_slot     (push_slot),
		.led_next      (led_next),
		.mask_next     (mask_next),
		.pwr_next      (pwr_next)
	);

	// Angle store at acceptance; the get-servo read is issued on every beat
	scbd_ram #(.WIDTH(16), .DEPTH(SERVO_COUNT)) u_servo_ram (
		.clk   (clk),
		.we    (fire && ctl.ang_wr),
		.waddr (ang_idx),
		.wdata (ang_val),
		.re    (fire),
		.raddr (servo_rd_idx),
		.rdata (servo_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svld_q <= '0;
		end else if (fire && ctl.ang_wr) begin
			svld_q[ang_idx] <= 1'b1;
		end
	end

	// Never-written angles read as zero
	assign angle_rd = svld_q[srv_idx_s1] ? servo_q : 16'h0000;

	// Stage 1: control with reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (fire) begin
			vld_s1 <= 1'b1;
			ctl_s1 <= ctl;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ang_idx_s1   <= ang_idx;
			srv_idx_s1   <= servo_rd_idx;
			ang_val_s1   <= ang_val;
			push_slot_s1 <= push_slot;
			led_s1       <= led_next;
			mask_s1      <= mask_next;
			pwr_s1       <= pwr_next;
			psense_s1    <= s_tdata[8];
		end
	end

	// Reply bytes are resolved when the beat leaves stage 1
	always_comb begin
		hi_data = angle_rd[15:8];
		unique case (ctl_s1.kind)
			PK_SERVO: lo_data = angle_rd[7:0];
			PK_LED:   lo_data = {5'b0, led_s1};
			PK_POWER: lo_data = {7'b0, psense_s1};
			PK_NONE:  lo_data = 8'h00;
		endcase
	end

	scbd_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_go    (adv),
		.lo_en    (ctl_s1.push_lo),
		.hi_en    (ctl_s1.push_hi),
		.lo_slot  (push_slot_s1),
		.lo_data  (lo_data),
		.hi_data  (hi_data),
		.pop_go   (fire && s_tuser),
		.pop_slot (pop_slot),
		.pop_byte (pop_byte)
	);

	// Result beat assembly
	always_comb begin
		out_d        = '0;
		out_d[7:0]   = ctl_s1.is_read ? pop_byte : 8'h00;
		out_d[8]     = ctl_s1.seen;
		out_d[9]     = ctl_s1.ang_wr;
		out_d[12:10] = ctl_s1.ang_wr ? 3'(ang_idx_s1) : 3'b000;
		out_d[28:13] = ctl_s1.ang_wr ? ang_val_s1 : 16'h0000;
		out_d[31:29] = led_s1;
		out_d[34:32] = mask_s1;
		out_d[35]    = pwr_s1;
	end

	// Output register parts the two sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_d;
		end
	end

endmodule

// File: rtl/scbd_checker.sv
// Port-level checks for the servo command byte decoder, bound to the top.
// Depends on scbd_pkg and servo_command_byte_decoder.
module scbd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [scbd_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import scbd_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// With the output register empty the pipe can always take a beat
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// Index and angle are zero unless an angle was stored
	a_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> m_tdata[28:10] == '0)
		else $error("angle fields set without angle_write");

	// A byte is either a command or an angle low byte, never both
	a_seen_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
		else $error("command_seen and angle_write together");

endmodule

bind servo_command_byte_decoder scbd_checker u_scbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
